[design/ieval_pkg.sv]
// ----------------------------------------------------------------------------
// Infix evaluator package
// Shared sizes, character codes, operator and status codes, sequencer states
// and small helper functions for the infix expression evaluator.
// ----------------------------------------------------------------------------
package ieval_pkg;

  localparam int VALUE_DEPTH         = 16;
  localparam int OPERATOR_DEPTH      = 16;
  localparam int FRACTION_BITS       = 16;
  localparam int MAX_FRACTION_DIGITS = 6;

  localparam int VALUE_W = 48;
  localparam int NUM_W   = VALUE_W + FRACTION_BITS;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int VC_W    = $clog2(VALUE_DEPTH + 1);
  localparam int VI_W    = $clog2(VALUE_DEPTH);
  localparam int OC_W    = $clog2(OPERATOR_DEPTH + 1);
  localparam int OI_W    = $clog2(OPERATOR_DEPTH);
  localparam int FD_W    = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // ASCII characters the parser reacts to.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LPAR    = 8'h28;
  localparam logic [7:0] CH_RPAR    = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    OP_PAREN = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIV0      = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_FULL      = 3'd3,
    ST_SAT       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_DISPATCH,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_WAIT_ALU,
    S_EOL_RD,
    S_EOL_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] mag;
  } alu_rsp_t;

  // Operator precedence: parenthesis lowest, then add/subtract.
  function automatic logic [1:0] prec(input op_t op);
    case (op)
      OP_PAREN:       return 2'd0;
      OP_ADD, OP_SUB: return 2'd1;
      default:        return 2'd2;
    endcase
  endfunction

  // Hard errors replace ok or saturated; the first hard error sticks.
  function automatic status_t raise_err(input status_t cur, input status_t e);
    if (cur == ST_OK || cur == ST_SAT) return e;
    return cur;
  endfunction

  function automatic status_t note_sat(input status_t cur);
    if (cur == ST_OK) return ST_SAT;
    return cur;
  endfunction

  function automatic logic is_failed(input status_t cur);
    return (cur != ST_OK) && (cur != ST_SAT);
  endfunction

  // Power of ten, used with constant arguments only.
  function automatic logic [VALUE_W-1:0] pow10(input int n);
    logic [VALUE_W-1:0] p;
    p = VALUE_W'(1);
    for (int i = 0; i < n; i++) p = p * VALUE_W'(10);
    return p;
  endfunction

endpackage

[design/ieval_if.sv]
// ----------------------------------------------------------------------------
// Infix evaluator channels
// Valid/ready channels for the character requests and the result requests.
// ----------------------------------------------------------------------------
interface ieval_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ieval_out_if;
  import ieval_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [2:0]                status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

[design/ieval_alu.sv]
// ----------------------------------------------------------------------------
// Infix evaluator arithmetic unit
// Shared bit-serial unit: shift-add multiply of two magnitudes (one bit per
// cycle) or restoring divide of a wide numerator (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module ieval_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  ieval_pkg::alu_req_t           req,
  input  logic [ieval_pkg::NUM_W-1:0]   op_a,
  input  logic [ieval_pkg::VALUE_W-1:0] op_b,
  output ieval_pkg::alu_rsp_t           rsp
);
  import ieval_pkg::*;

  logic               busy;
  logic               done;
  logic               is_div;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] mcand;
  logic [VALUE_W-1:0] rem;
  logic [NUM_W-1:0]   quo;
  logic [VALUE_W-1:0] den;

  logic [VALUE_W:0]   mul_sum;
  logic [VALUE_W:0]   div_try;
  logic               div_ge;
  logic [VALUE_W:0]   div_diff;

  // One multiply step and one divide step.
  always_comb begin
    mul_sum  = {1'b0, prod[PROD_W-1:VALUE_W]} + (prod[0] ? {1'b0, mcand} : '0);
    div_try  = {rem, quo[NUM_W-1]};
    div_ge   = div_try >= {1'b0, den};
    div_diff = div_try - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      cnt    <= req.is_div ? CNT_W'(NUM_W) : CNT_W'(VALUE_W);
      prod   <= {{VALUE_W{1'b0}}, op_b};
      mcand  <= op_a[VALUE_W-1:0];
      quo    <= op_a;
      rem    <= '0;
      den    <= op_b;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (is_div) begin
        rem <= div_ge ? div_diff[VALUE_W-1:0] : div_try[VALUE_W-1:0];
        quo <= {quo[NUM_W-2:0], div_ge};
      end else begin
        prod <= {mul_sum, prod[VALUE_W-1:1]};
      end
    end
  end

  // Product is rescaled by the fraction bits; quotient is taken as is.
  assign rsp.done = done;
  assign rsp.mag  = is_div ? PROD_W'(quo) : PROD_W'(prod[PROD_W-1:FRACTION_BITS]);

endmodule

[design/infix_expression_evaluator.sv]
// A digit or a plain character is taken in the idle state; ending a number runs
// the shared divider to scale it; a + or - reduction is done directly, while
// * and / reductions run the shared serial multiply/divide unit.
// Characters are taken one at a time and only while idle; the serial multiply/divide unit sets the pace.
// A newline result is registered after its last reduction, once the output register is free.
// Reset (synchronous) clears the counts, number state, error and the result.
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Shunting-yard evaluation of ASCII characters into a Q31.16 fixed-point
// result, with value and operator stacks and a shared serial arithmetic unit.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
  input logic         clk,
  input logic         rst,
  ieval_in_if.sink    chars,
  ieval_out_if.source results
);
  import ieval_pkg::*;

  state_t state, state_next;
  logic [7:0]         ch, ch_next;
  logic [VC_W-1:0]    vc, vc_next;
  logic [OC_W-1:0]    oc, oc_next;
  logic [VALUE_W-1:0] mant, mant_next;
  logic [FD_W-1:0]    fd, fd_next;
  logic               active, active_next;
  logic               point, point_next;
  status_t            err, err_next;
  op_t                cur_op, cur_op_next;
  logic [VALUE_W-1:0] opb, opb_next;
  logic               neg, neg_next;
  logic               out_valid, ov_next;
  logic [VALUE_W-1:0] out_value, oval_next;
  status_t            out_status, ost_next;

  op_t                opstk [OPERATOR_DEPTH];
  logic               op_we;
  op_t                op_wdata;

  logic [VALUE_W-1:0] vmem [VALUE_DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic               we;
  logic [VI_W-1:0]    waddr;
  logic [VI_W-1:0]    raddr;
  logic [VALUE_W-1:0] wdata;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [NUM_W-1:0]   alu_a;
  logic [VALUE_W-1:0] alu_b;

  logic [VALUE_W-1:0] pow10_tab [MAX_FRACTION_DIGITS+1];

  // Constant table of divisors for the fraction digits.
  for (genvar k = 0; k <= MAX_FRACTION_DIGITS; k++) begin : g_pow10
    assign pow10_tab[k] = pow10(k);
  end

  ieval_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .op_a (alu_a),
    .op_b (alu_b),
    .rsp  (alu_rsp)
  );

  // Helper values for the sequencer.
  logic               failed;
  op_t                top_op;
  logic [OI_W-1:0]    oc_top;
  logic [VALUE_W+3:0] m10;
  logic               m_ovf;
  logic               fl_sat;
  logic [VALUE_W-1:0] fl_val;
  logic               fm_sat;
  logic [VALUE_W-1:0] fm_val;
  logic [VALUE_W:0]   as_sum;
  logic               as_sat;
  logic [VALUE_W-1:0] as_val;
  logic [VALUE_W-1:0] mag_a;
  logic [VALUE_W-1:0] mag_b;
  logic [VC_W-1:0]    vc_m1;
  logic [VC_W-1:0]    vc_m2;
  logic               reduce_req;
  logic               push_req;
  op_t                push_opc;
  op_t                ch_op;
  status_t            e;

  always_comb begin
    failed = is_failed(err);
    oc_top = OI_W'(oc - OC_W'(1));
    top_op = opstk[oc_top];
    vc_m1  = vc - VC_W'(1);
    vc_m2  = vc - VC_W'(2);
    m10    = ({4'b0, mant} << 3) + ({4'b0, mant} << 1) +
             (VALUE_W+4)'(chars.char_code[3:0]);
    m_ovf  = |m10[VALUE_W+3:VALUE_W];
    fl_sat = |alu_rsp.mag[PROD_W-1:VALUE_W-1];
    fl_val = fl_sat ? VAL_MAX : alu_rsp.mag[VALUE_W-1:0];
    fm_sat = neg ? (alu_rsp.mag > PROD_W'(VAL_MIN)) : (alu_rsp.mag > PROD_W'(VAL_MAX));
    fm_val = fm_sat ? (neg ? VAL_MIN : VAL_MAX)
                    : (neg ? VALUE_W'(-alu_rsp.mag[VALUE_W-1:0])
                           : alu_rsp.mag[VALUE_W-1:0]);
    mag_a  = rdata[VALUE_W-1] ? VALUE_W'(-rdata) : rdata;
    mag_b  = opb[VALUE_W-1] ? VALUE_W'(-opb) : opb;
    if (cur_op == OP_SUB) as_sum = {rdata[VALUE_W-1], rdata} - {opb[VALUE_W-1], opb};
    else                  as_sum = {rdata[VALUE_W-1], rdata} + {opb[VALUE_W-1], opb};
    as_sat = as_sum[VALUE_W] != as_sum[VALUE_W-1];
    as_val = as_sat ? (as_sum[VALUE_W] ? VAL_MIN : VAL_MAX) : as_sum[VALUE_W-1:0];
    case (ch)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      default:  ch_op = OP_DIV;
    endcase
  end

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_next  = state;
    ch_next     = ch;
    vc_next     = vc;
    oc_next     = oc;
    mant_next   = mant;
    fd_next     = fd;
    active_next = active;
    point_next  = point;
    err_next    = err;
    cur_op_next = cur_op;
    opb_next    = opb;
    neg_next    = neg;
    ov_next     = out_valid && !results.ready;
    oval_next   = out_value;
    ost_next    = out_status;
    op_we       = 1'b0;
    op_wdata    = OP_PAREN;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    alu_req     = '0;
    alu_a       = {mant, {FRACTION_BITS{1'b0}}};
    alu_b       = pow10_tab[fd];
    reduce_req  = 1'b0;
    push_req    = 1'b0;
    push_opc    = OP_PAREN;
    e           = err;

    case (state)
      S_IDLE: begin
        if (chars.valid) begin
          ch_next = chars.char_code;
          if (chars.char_code == CH_NEWLINE) begin
            if (!failed && active) begin
              alu_req    = '{start: 1'b1, is_div: 1'b1};
              state_next = S_FLUSH;
            end else begin
              state_next = S_DISPATCH;
            end
          end else if (failed) begin
            state_next = S_IDLE;
          end else if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE) begin
            // Accumulate a decimal digit; extra fraction digits are dropped.
            active_next = 1'b1;
            if (!(point && fd >= FD_W'(MAX_FRACTION_DIGITS))) begin
              if (m_ovf) begin
                mant_next = '1;
                err_next  = note_sat(err);
              end else begin
                mant_next = m10[VALUE_W-1:0];
              end
              if (point) fd_next = fd + FD_W'(1);
            end
          end else if (chars.char_code == CH_POINT && !(active && point)) begin
            active_next = 1'b1;
            point_next  = 1'b1;
          end else if (active) begin
            alu_req    = '{start: 1'b1, is_div: 1'b1};
            state_next = S_FLUSH;
          end else begin
            state_next = S_DISPATCH;
          end
        end
      end

      S_FLUSH: begin
        // Finished number goes onto the value stack.
        if (alu_rsp.done) begin
          if (fl_sat) e = note_sat(e);
          mant_next   = '0;
          fd_next     = '0;
          active_next = 1'b0;
          point_next  = 1'b0;
          if (vc >= VC_W'(VALUE_DEPTH)) begin
            e = raise_err(e, ST_FULL);
          end else begin
            we      = 1'b1;
            waddr   = vc[VI_W-1:0];
            wdata   = fl_val;
            vc_next = vc + VC_W'(1);
          end
          err_next   = e;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next = S_IDLE;
        case (ch)
          CH_NEWLINE: begin
            if (!failed && oc != '0) begin
              state_next = S_DISPATCH;
              if (top_op == OP_PAREN) err_next = raise_err(err, ST_MALFORMED);
              else                    reduce_req = 1'b1;
            end else begin
              if (!failed && vc != VC_W'(1)) err_next = raise_err(err, ST_MALFORMED);
              state_next = S_EOL_RD;
            end
          end
          CH_POINT: begin
            active_next = 1'b1;
            point_next  = 1'b1;
          end
          CH_LPAR: begin
            if (!failed) push_req = 1'b1;
          end
          CH_RPAR: begin
            if (!failed && oc != '0 && top_op != OP_PAREN) begin
              reduce_req = 1'b1;
            end else if (!failed) begin
              if (oc == '0) err_next = raise_err(err, ST_MALFORMED);
              else          oc_next  = oc - OC_W'(1);
            end
          end
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
            if (!failed && oc != '0 && prec(top_op) >= prec(ch_op)) begin
              reduce_req = 1'b1;
            end else if (!failed) begin
              push_req = 1'b1;
              push_opc = ch_op;
            end
          end
          default: state_next = S_IDLE;
        endcase

        // Operator push.
        if (push_req) begin
          if (oc >= OC_W'(OPERATOR_DEPTH)) begin
            err_next = raise_err(err, ST_FULL);
          end else begin
            op_we    = 1'b1;
            op_wdata = push_opc;
            oc_next  = oc + OC_W'(1);
          end
        end

        // Start of one reduction: pop the operator, then fetch two operands.
        if (reduce_req) begin
          if (vc < VC_W'(2)) begin
            err_next   = raise_err(err, ST_MALFORMED);
            state_next = S_DISPATCH;
          end else begin
            cur_op_next = top_op;
            oc_next     = oc - OC_W'(1);
            state_next  = S_RD_B;
          end
        end
      end

      S_RD_B: begin
        raddr      = vc_m1[VI_W-1:0];
        state_next = S_RD_A;
      end

      S_RD_A: begin
        raddr      = vc_m2[VI_W-1:0];
        opb_next   = rdata;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        vc_next    = vc_m1;
        waddr      = vc_m2[VI_W-1:0];
        wdata      = as_val;
        neg_next   = rdata[VALUE_W-1] ^ opb[VALUE_W-1];
        alu_b      = mag_b;
        state_next = S_DISPATCH;
        case (cur_op)
          OP_ADD, OP_SUB: begin
            we = 1'b1;
            if (as_sat) err_next = note_sat(err);
          end
          OP_MUL: begin
            alu_req    = '{start: 1'b1, is_div: 1'b0};
            alu_a      = NUM_W'(mag_a);
            state_next = S_WAIT_ALU;
          end
          OP_DIV: begin
            if (opb == '0) begin
              err_next = raise_err(err, ST_DIV0);
            end else begin
              alu_req    = '{start: 1'b1, is_div: 1'b1};
              alu_a      = {mag_a, {FRACTION_BITS{1'b0}}};
              state_next = S_WAIT_ALU;
            end
          end
          default: state_next = S_DISPATCH;
        endcase
      end

      S_WAIT_ALU: begin
        if (alu_rsp.done) begin
          we    = 1'b1;
          waddr = vc_m1[VI_W-1:0];
          wdata = fm_val;
          if (fm_sat) err_next = note_sat(err);
          state_next = S_DISPATCH;
        end
      end

      S_EOL_RD: begin
        state_next = S_EOL_OUT;
      end

      S_EOL_OUT: begin
        // Result goes out once the output register is free; then clear up.
        if (!out_valid || results.ready) begin
          ov_next     = 1'b1;
          oval_next   = failed ? '0 : rdata;
          ost_next    = err;
          vc_next     = '0;
          oc_next     = '0;
          mant_next   = '0;
          fd_next     = '0;
          active_next = 1'b0;
          point_next  = 1'b0;
          err_next    = ST_OK;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control and number registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vc        <= '0;
      oc        <= '0;
      mant      <= '0;
      fd        <= '0;
      active    <= 1'b0;
      point     <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      vc        <= vc_next;
      oc        <= oc_next;
      mant      <= mant_next;
      fd        <= fd_next;
      active    <= active_next;
      point     <= point_next;
      err       <= err_next;
      out_valid <= ov_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch         <= ch_next;
    cur_op     <= cur_op_next;
    opb        <= opb_next;
    neg        <= neg_next;
    out_value  <= oval_next;
    out_status <= ost_next;
  end

  // Operator stack, read at its top only.
  always_ff @(posedge clk) begin
    if (op_we) opstk[oc[OI_W-1:0]] <= op_wdata;
  end

  // Value stack memory with registered read.
  always_ff @(posedge clk) begin
    if (we) vmem[waddr] <= wdata;
    rdata <= vmem[raddr];
  end

  assign chars.ready    = (state == S_IDLE);
  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

endmodule

[design/ieval_checker.sv]
// ----------------------------------------------------------------------------
// Infix evaluator checker
// Port-level assertions on the evaluator, attached by a bind statement.
// ----------------------------------------------------------------------------
module ieval_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    in_char,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ieval_pkg::VALUE_W-1:0] out_value,
  input logic [2:0]                    out_status
);
  import ieval_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  // Hard errors always report a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_DIV0 || out_status == ST_MALFORMED ||
                  out_status == ST_FULL) |-> out_value == '0)
    else $error("non-zero value with error status");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_SAT)
    else $error("undefined status code");

  // A newline starts the end-of-line evaluation, so no request follows at once.
  a_eol_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_char == CH_NEWLINE |=> !in_ready)
    else $error("request taken straight after a newline");

endmodule

bind infix_expression_evaluator ieval_checker u_ieval_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .in_char    (chars.char_code),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.value),
  .out_status (results.status)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Infix evaluator testbench
// Sends ASCII character requests to the evaluator and checks each result
// request, value and status, against an evaluator model that the bench keeps.
// The bench checks directed expressions first, then random expressions, while
// both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ieval_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] MANT_CAP = 64'hFFFF_FFFF_FFFF;
  localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000_0000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } eval_result_t;

  logic clk;
  logic rst;

  ieval_in_if  chars ();
  ieval_out_if results ();

  infix_expression_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars.sink),
    .results(results.source)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state of the evaluator.
  longint      vals [VALUE_DEPTH];
  op_t         ops  [OPERATOR_DEPTH];
  int          nvals;
  int          nops;
  logic [63:0] mant;
  int          fdigits;
  bit          in_number;
  bit          have_point;
  status_t     err;

  logic [7:0]   char_queue [$];
  eval_result_t expected_results [$];
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  hold_count;
  int  errors;
  int  n_sent;
  int  n_results;
  int  idle_cycles;

  // Clamp a wide signed result to 48 bits and note saturation.
  function automatic longint clamp(input logic signed [127:0] x);
    if (x > SAT_HI) begin
      err = note_sat(err);
      return SAT_HI;
    end
    if (x < SAT_LO) begin
      err = note_sat(err);
      return SAT_LO;
    end
    return longint'(x);
  endfunction

  function automatic void fail_with(input status_t e);
    err = raise_err(err, e);
  endfunction

  function automatic void push_val(input longint v);
    if (nvals >= VALUE_DEPTH) fail_with(ST_FULL);
    else begin
      vals[nvals] = v;
      nvals++;
    end
  endfunction

  function automatic void push_op(input op_t o);
    if (nops >= OPERATOR_DEPTH) fail_with(ST_FULL);
    else begin
      ops[nops] = o;
      nops++;
    end
  endfunction

  // Pop one operator and two values, apply it and push the result back.
  function automatic void apply_top();
    longint a, b;
    logic signed [127:0] w;
    op_t o;
    if (nops == 0 || nvals < 2 || ops[nops-1] == OP_PAREN) begin
      fail_with(ST_MALFORMED);
      return;
    end
    nops--;
    o = ops[nops];
    nvals--;
    b = vals[nvals];
    a = vals[nvals-1];
    case (o)
      OP_ADD: vals[nvals-1] = clamp(128'(a) + 128'(b));
      OP_SUB: vals[nvals-1] = clamp(128'(a) - 128'(b));
      OP_MUL: begin
        // Truncation toward zero of the scaled product.
        w = 128'(a) * 128'(b);
        if (w < 0) w = -((-w) >>> FRACTION_BITS);
        else w = w >>> FRACTION_BITS;
        vals[nvals-1] = clamp(w);
      end
      default: begin
        if (b == 0) begin
          fail_with(ST_DIV0);
          return;
        end
        w = (128'(a) <<< FRACTION_BITS) / 128'(b);
        vals[nvals-1] = clamp(w);
      end
    endcase
  endfunction

  // Convert the pending decimal digits to fixed point and push them.
  function automatic void end_number();
    logic [63:0] p10, q, r, v;
    if (!in_number) return;
    p10 = 64'd1;
    for (int i = 0; i < fdigits; i++) p10 = p10 * 64'd10;
    q = mant / p10;
    r = mant % p10;
    if (q > (64'(SAT_HI) >> FRACTION_BITS)) begin
      err = note_sat(err);
      v = 64'(SAT_HI);
    end else begin
      v = (q << FRACTION_BITS) + ((r << FRACTION_BITS) / p10);
    end
    mant = '0;
    fdigits = 0;
    in_number = 0;
    have_point = 0;
    push_val(longint'(v));
  endfunction

  function automatic void clear_line();
    nvals = 0;
    nops = 0;
    mant = '0;
    fdigits = 0;
    in_number = 0;
    have_point = 0;
    err = ST_OK;
  endfunction

  function automatic int rank(input op_t o);
    return (o == OP_ADD || o == OP_SUB) ? 1 : (o == OP_PAREN) ? 0 : 2;
  endfunction

  // Advance the model by one character and queue a result on a newline.
  function automatic void evaluate_char(input logic [7:0] c);
    eval_result_t res;
    logic [63:0] d;
    op_t o;
    if (c == CH_NEWLINE) begin
      if (!is_failed(err)) end_number();
      while (!is_failed(err) && nops > 0) begin
        if (ops[nops-1] == OP_PAREN) fail_with(ST_MALFORMED);
        else apply_top();
      end
      if (!is_failed(err) && nvals != 1) fail_with(ST_MALFORMED);
      res.value = is_failed(err) ? '0 : VALUE_W'(vals[0]);
      res.status = err;
      expected_results.push_back(res);
      clear_line();
      return;
    end
    if (is_failed(err)) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      in_number = 1;
      if (have_point && fdigits >= MAX_FRACTION_DIGITS) return;
      if (mant > (MANT_CAP - d) / 64'd10) begin
        mant = MANT_CAP;
        err = note_sat(err);
      end else begin
        mant = mant * 64'd10 + d;
      end
      if (have_point) fdigits++;
      return;
    end
    if (c == CH_POINT) begin
      if (in_number && have_point) end_number();
      in_number = 1;
      have_point = 1;
      return;
    end
    end_number();
    if (is_failed(err)) return;
    if (c == CH_LPAR) begin
      push_op(OP_PAREN);
    end else if (c == CH_RPAR) begin
      while (!is_failed(err) && nops > 0 && ops[nops-1] != OP_PAREN) apply_top();
      if (is_failed(err)) return;
      if (nops == 0) fail_with(ST_MALFORMED);
      else nops--;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      o = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
          (c == CH_STAR) ? OP_MUL : OP_DIV;
      while (!is_failed(err) && nops > 0 && rank(ops[nops-1]) >= rank(o)) apply_top();
      if (!is_failed(err)) push_op(o);
    end
  endfunction

  // Stimulus helpers that append characters to the pending queue.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
  endtask

  task automatic add_number();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) char_queue.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      char_queue.push_back(CH_POINT);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) char_queue.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic add_operator();
    case ($urandom_range(0, 3))
      0: char_queue.push_back(CH_PLUS);
      1: char_queue.push_back(CH_MINUS);
      2: char_queue.push_back(CH_STAR);
      default: char_queue.push_back(CH_SLASH);
    endcase
  endtask

  // A well-formed expression with random content and nesting.
  task automatic add_expression(input int depth);
    int terms;
    terms = $urandom_range(1, 3);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) add_operator();
      if ($urandom_range(0, 7) == 0) char_queue.push_back(8'h20);
      if (depth < 3 && $urandom_range(0, 3) == 0) begin
        char_queue.push_back(CH_LPAR);
        add_expression(depth + 1);
        char_queue.push_back(CH_RPAR);
      end else begin
        add_number();
      end
    end
  endtask

  // Driver: one character request per handshake, stalling at random.
  always @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      chars.char_code <= '0;
    end else if (!chars.valid || chars.ready) begin
      if (chars.valid) begin
        evaluate_char(chars.char_code);
        n_sent++;
      end
      if (char_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        chars.valid <= 1'b1;
        chars.char_code <= char_queue.pop_front();
      end else begin
        chars.valid <= 1'b0;
      end
    end
  end

  // Receiver stall and the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      hold_count <= 0;
    end else if (hold_off && hold_count < 3000) begin
      hold_count <= hold_count + 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result request with the oldest expectation.
  always @(posedge clk) begin
    eval_result_t exp_res;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((chars.valid && chars.ready) || (results.valid && results.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (results.valid && results.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   results.value, results.status);
        end else begin
          exp_res = expected_results.pop_front();
          if (results.value !== exp_res.value || results.status !== exp_res.status) begin
            errors++;
            $display("%0t: mismatch expected value=%0d status=%0d, actual value=%0d status=%0d",
                     $time, exp_res.value, exp_res.status, results.value, results.status);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("infix_expression_evaluator verification failed");
        $finish;
      end
    end
  end

  // Wait until every pending character has been accepted.
  task automatic drain_chars();
    while (char_queue.size() > 0 || chars.valid) @(posedge clk);
  endtask

  initial begin
    chars.valid = 1'b0;
    chars.char_code = '0;
    results.ready = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 71;
    hold_off = 0;
    errors = 0;
    n_sent = 0;
    n_results = 0;
    clear_line();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed expressions: precedence, parentheses and each special case.
    add_text("1+2*3-4/2\n(1+2)*3\n7/0\n");
    add_text("1.2.5+\n.\n\n1 2\n)\n(1\n+\n");
    add_text("0.1234567890*3\n999999999999999*99999\n99999999999999999999\n");
    add_text("140737488/0.000001\nab%-*$\n");
    char_queue.push_back(8'hFF);
    char_queue.push_back(8'h80);
    char_queue.push_back(CH_NEWLINE);
    // Sixteen open parentheses fill the operator stack, seventeen overflow it.
    for (int i = 0; i < 17; i++) char_queue.push_back(CH_LPAR);
    add_text("1\n");
    // Sixteen nested 1+( terms push two operators each and overflow the operator stack.
    for (int i = 0; i < 16; i++) add_text("1+(");
    add_text("1\n");
    drain_chars();

    // Random phases with different stall patterns.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 38 : 0;
      if (phase == 2) hold_off = 1;
      for (int k = 0; k < 35; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            // Noise: any character code at all.
            for (int i = 0; i < $urandom_range(1, 8); i++)
              char_queue.push_back(8'($urandom_range(0, 255)));
          end
          1: begin
            // A broken expression.
            add_expression(0);
            char_queue.push_back($urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
          end
          default: add_expression(0);
        endcase
        char_queue.push_back(CH_NEWLINE);
      end
      drain_chars();
    end

    // Let the last results arrive.
    while (expected_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d characters and checked %0d results, with stalls on both sides.",
             n_sent, n_results);
    if (errors == 0 && expected_results.size() == 0)
      $display("infix_expression_evaluator verification clean");
    else
      $display("infix_expression_evaluator verification failed");
    $finish;
  end

endmodule
